FILE: hw/rtl/rls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_pkg: shared types, constants and saturation helpers
// Fixed-point formats, register indexes and the request and response structs
// that connect the sequencer to the multiply and divide units.
// ----------------------------------------------------------------------------
package rls_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COV_WIDTH   = 48;
	localparam int LAMBDA_FRAC = 30;

	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// configuration register indexes
	localparam logic [1:0] REG_LAMBDA = 2'd0;
	localparam logic [1:0] REG_DELTA  = 2'd1;
	localparam logic [1:0] REG_INIT1  = 2'd2;
	localparam logic [1:0] REG_INIT2  = 2'd3;

	typedef logic signed [COV_WIDTH-1:0] cov_t;

	// request to a shared unit; lam_shift picks the lambda scaling for a divide
	typedef struct packed {
		logic               start;
		logic               lam_shift;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} op_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] res;
	} op_rsp_t;

	// add clamped to +-(2^63 - 1)
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SMAX))
			return SMAX;
		else if (s < -65'(SMAX))
			return -SMAX;
		else
			return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sh8000_0000)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic cov_t sat_cov(input logic signed [63:0] v);
		logic signed [63:0] mx;
		mx = 64'((64'd1 << (COV_WIDTH - 1)) - 64'd1);
		if (v > mx)
			return cov_t'(mx);
		else if (v < -mx - 64'sd1)
			return cov_t'(-mx - 64'sd1);
		else
			return cov_t'(v);
	endfunction

endpackage

FILE: hw/rtl/rls_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_mul: iterative fixed-point multiplier
// trunc(a*b / 2^FRAC_BITS) on 64-bit signed operands, saturated to
// +-(2^63 - 1). Four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module rls_mul
	import rls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  op_req_t req,
	output op_rsp_t rsp
);

	logic [63:0]        x_q, y_q;
	logic               neg_q;
	logic [127:0]       acc_q;
	logic [63:0]        prod_q;
	logic [1:0]         pidx_q;
	logic [2:0]         ph_q;
	logic               busy_q, done_q;
	logic signed [63:0] res_q;

	logic [31:0]  xsel, ysel;
	logic [127:0] prod_sh, acc_sh;
	logic [63:0]  mag_r;

	assign xsel = ph_q[1] ? x_q[63:32] : x_q[31:0];
	assign ysel = ph_q[0] ? y_q[63:32] : y_q[31:0];

	// align the previous partial product
	always_comb begin
		case (pidx_q)
			2'd0:    prod_sh = {64'd0, prod_q};
			2'd3:    prod_sh = {prod_q, 64'd0};
			default: prod_sh = {32'd0, prod_q, 32'd0};
		endcase
	end

	// scale and saturate the magnitude
	assign acc_sh = acc_q >> FRAC_BITS;
	assign mag_r  = (|acc_sh[127:63]) ? SMAX : acc_sh[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.a[63] ? 64'd0 - req.a : req.a;
			y_q   <= req.b[63] ? 64'd0 - req.b : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (ph_q < 3'd4) begin
				prod_q <= 64'(xsel) * 64'(ysel);
				pidx_q <= ph_q[1:0];
			end
			if (ph_q != 3'd0 && ph_q <= 3'd4)
				acc_q <= acc_q + prod_sh;
			if (ph_q == 3'd5)
				res_q <= neg_q ? -$signed(mag_r) : $signed(mag_r);
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

FILE: hw/rtl/rls_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_div: bit-serial fixed-point divider
// trunc(a * 2^s / b), s = FRAC_BITS or LAMBDA_FRAC, saturated; a zero
// divisor gives the saturated sign of a. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rls_div
	import rls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  op_req_t req,
	output op_rsp_t rsp
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_ITER = 2'd1;
	localparam logic [1:0] D_FIN  = 2'd2;
	localparam logic [1:0] D_ZERO = 2'd3;

	logic [1:0]         st_q;
	logic [6:0]         cnt_q;
	logic [127:0]       num_q, quo_q;
	logic [63:0]        rem_q, d_q;
	logic               neg_q, nz_q, aneg_q, done_q;
	logic signed [63:0] res_q;

	logic [63:0]  n_mag, d_mag;
	logic [127:0] num_init;
	logic [64:0]  rem2, diff;
	logic         ge;
	logic [63:0]  mag_r;

	assign n_mag    = req.a[63] ? 64'd0 - req.a : req.a;
	assign d_mag    = req.b[63] ? 64'd0 - req.b : req.b;
	assign num_init = req.lam_shift ? ({64'd0, n_mag} << LAMBDA_FRAC)
	                                : ({64'd0, n_mag} << FRAC_BITS);

	// restoring step
	assign rem2 = {rem_q, num_q[127]};
	assign diff = rem2 - {1'b0, d_q};
	assign ge   = (rem2 >= {1'b0, d_q});

	assign mag_r = (|quo_q[127:63]) ? SMAX : quo_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (req.start) begin
						st_q  <= (d_mag == 64'd0) ? D_ZERO : D_ITER;
						cnt_q <= '0;
					end
				end
				D_ITER: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127)
						st_q <= D_FIN;
				end
				D_FIN, D_ZERO: begin
					st_q   <= D_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				num_q  <= num_init;
				d_q    <= d_mag;
				rem_q  <= '0;
				quo_q  <= '0;
				neg_q  <= req.a[63] ^ req.b[63];
				aneg_q <= req.a[63];
				nz_q   <= (n_mag != 64'd0);
			end
			D_ITER: begin
				rem_q <= ge ? diff[63:0] : rem2[63:0];
				num_q <= {num_q[126:0], 1'b0};
				quo_q <= {quo_q[126:0], ge};
			end
			D_FIN:  res_q <= neg_q ? -$signed(mag_r) : $signed(mag_r);
			D_ZERO: res_q <= !nz_q ? 64'sd0 : (aneg_q ? -SMAX : SMAX);
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

FILE: hw/rtl/rls_two_param_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_two_param_estimator: two-parameter RLS estimator, forgetting factor
// Sequencer over one shared multiplier and one shared divider; holds the
// covariance, estimates, gains and update counter.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  config    in         wr_en                       wr_index, wr_data
//  item      in         item_valid / item_stall     mode, regressors, output
//  result    out        result_valid / result_stall estimates, gains, count, skip
//
// A restart transaction goes from acceptance straight to the finish state,
// which loads its result; the next transaction is then accepted in the idle
// state. An update runs 22 multiplies and 6 divides (bit-serial divider) plus
// two steps done without a unit (denominator and error) before the finish
// state loads its result. A zero denominator ends it after the first 6
// multiplies. item_stall is high from acceptance until the result is loaded
// into the output register; a stalled result register holds and blocks
// only the next load. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rls_two_param_estimator
	import rls_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               mode,
	input  logic signed [31:0] regressor_a,
	input  logic signed [31:0] regressor_b,
	input  logic signed [31:0] measured_output,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] param_one,
	output logic signed [31:0] param_two,
	output logic signed [31:0] gain_one,
	output logic signed [31:0] gain_two,
	output logic [31:0]        update_count,
	output logic               skipped
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// sequencer steps
	localparam logic [4:0] S_PP0A = 5'd0,  S_PP0B = 5'd1,  S_PP1A = 5'd2,  S_PP1B = 5'd3;
	localparam logic [4:0] S_QA   = 5'd4,  S_QB   = 5'd5,  S_DEN  = 5'd6;
	localparam logic [4:0] S_K0   = 5'd7,  S_K1   = 5'd8;
	localparam logic [4:0] S_PRA  = 5'd9,  S_PRB  = 5'd10, S_ERR  = 5'd11;
	localparam logic [4:0] S_E0   = 5'd12, S_E1   = 5'd13;
	localparam logic [4:0] S_KP0  = 5'd14, S_KP1  = 5'd15, S_KP2  = 5'd16, S_KP3  = 5'd17;
	localparam logic [4:0] S_T0A  = 5'd18, S_T0B  = 5'd19, S_T1A  = 5'd20, S_T1B  = 5'd21;
	localparam logic [4:0] S_T2A  = 5'd22, S_T2B  = 5'd23, S_T3A  = 5'd24, S_T3B  = 5'd25;
	localparam logic [4:0] S_C0   = 5'd26, S_C1   = 5'd27, S_C2   = 5'd28, S_C3   = 5'd29;

	logic [1:0]         st_q;
	logic [4:0]         step_q;
	logic               launched_q, skip_q;

	logic [30:0]        lam_q, delta_q;
	cov_t               cov_q [4];
	logic signed [31:0] est_q [2];
	logic signed [31:0] gain_q [2];
	logic [31:0]        cnt_q;

	logic signed [31:0] phi0_q, phi1_q, y_q;
	logic signed [63:0] acc_q, pp0_q, pp1_q, den_q, err_q;
	logic signed [63:0] kp_q [4];
	logic signed [63:0] t_q [4];

	logic               res_valid_q;

	op_req_t            mul_req, div_req;
	op_rsp_t            mul_rsp, div_rsp;

	logic               accept, out_free, is_div, is_alu;
	logic signed [63:0] op_a, op_b, m, c0, c1, c2, c3, p0, p1, lam64, den_c;
	logic signed [31:0] e_new;

	assign accept   = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign item_stall = (st_q != ST_IDLE);

	assign c0 = 64'(cov_q[0]);
	assign c1 = 64'(cov_q[1]);
	assign c2 = 64'(cov_q[2]);
	assign c3 = 64'(cov_q[3]);
	assign p0 = 64'(phi0_q);
	assign p1 = 64'(phi1_q);
	assign lam64 = $signed({33'd0, lam_q});
	assign den_c = sadd($signed({33'd0, lam_q} >> (LAMBDA_FRAC - FRAC_BITS)), acc_q);

	always_comb begin
		is_div = (step_q == S_K0) || (step_q == S_K1) || (step_q >= S_C0);
		is_alu = (step_q == S_DEN) || (step_q == S_ERR);
	end

	// operand selection per step
	always_comb begin
		op_a = c0;
		op_b = p0;
		case (step_q)
			S_PP0A: begin op_a = c0;        op_b = p0; end
			S_PP0B: begin op_a = c1;        op_b = p1; end
			S_PP1A: begin op_a = c2;        op_b = p0; end
			S_PP1B: begin op_a = c3;        op_b = p1; end
			S_QA:   begin op_a = p0;        op_b = pp0_q; end
			S_QB:   begin op_a = p1;        op_b = pp1_q; end
			S_K0:   begin op_a = pp0_q;     op_b = den_q; end
			S_K1:   begin op_a = pp1_q;     op_b = den_q; end
			S_PRA:  begin op_a = p0;        op_b = 64'(est_q[0]); end
			S_PRB:  begin op_a = p1;        op_b = 64'(est_q[1]); end
			S_E0:   begin op_a = 64'(gain_q[0]); op_b = err_q; end
			S_E1:   begin op_a = 64'(gain_q[1]); op_b = err_q; end
			S_KP0:  begin op_a = 64'(gain_q[0]); op_b = p0; end
			S_KP1:  begin op_a = 64'(gain_q[0]); op_b = p1; end
			S_KP2:  begin op_a = 64'(gain_q[1]); op_b = p0; end
			S_KP3:  begin op_a = 64'(gain_q[1]); op_b = p1; end
			S_T0A:  begin op_a = kp_q[0];   op_b = c0; end
			S_T0B:  begin op_a = kp_q[1];   op_b = c2; end
			S_T1A:  begin op_a = kp_q[0];   op_b = c1; end
			S_T1B:  begin op_a = kp_q[1];   op_b = c3; end
			S_T2A:  begin op_a = kp_q[2];   op_b = c0; end
			S_T2B:  begin op_a = kp_q[3];   op_b = c2; end
			S_T3A:  begin op_a = kp_q[2];   op_b = c1; end
			S_T3B:  begin op_a = kp_q[3];   op_b = c3; end
			S_C0:   begin op_a = t_q[0];    op_b = lam64; end
			S_C1:   begin op_a = t_q[1];    op_b = lam64; end
			S_C2:   begin op_a = t_q[2];    op_b = lam64; end
			S_C3:   begin op_a = t_q[3];    op_b = lam64; end
			default: ;
		endcase
	end

	// unit launch
	always_comb begin
		mul_req.start     = (st_q == ST_RUN) && !launched_q && !is_div && !is_alu;
		mul_req.lam_shift = 1'b0;
		mul_req.a         = op_a;
		mul_req.b         = op_b;
		div_req.start     = (st_q == ST_RUN) && !launched_q && is_div;
		div_req.lam_shift = (step_q >= S_C0);
		div_req.a         = op_a;
		div_req.b         = op_b;
	end

	rls_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	rls_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign m = is_div ? div_rsp.res : mul_rsp.res;

	// estimate correction with floor at one LSB
	always_comb begin
		if (step_q == S_E0)
			e_new = sat32(sadd(64'(est_q[0]), m));
		else
			e_new = sat32(sadd(64'(est_q[1]), m));
		if (e_new < 32'sd1)
			e_new = 32'sd1;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= S_PP0A;
			launched_q  <= 1'b0;
			skip_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// result register: load from finish state, else drain
			if (st_q == ST_FIN && out_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						skip_q <= 1'b0;
						step_q <= S_PP0A;
						st_q   <= mode ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (mul_req.start || div_req.start)
						launched_q <= 1'b1;
					if (is_alu) begin
						if (step_q == S_DEN && den_c == 64'sd0) begin
							skip_q <= 1'b1;
							st_q   <= ST_FIN;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end else if (launched_q && (mul_rsp.done || div_rsp.done)) begin
						launched_q <= 1'b0;
						if (step_q == S_C3)
							st_q <= ST_FIN;
						else
							step_q <= step_q + 5'd1;
					end
				end
				ST_FIN: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// architectural state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q     <= 31'd1063004406;
			delta_q   <= 31'd65536000;
			est_q[0]  <= 32'sd65536;
			est_q[1]  <= 32'sd65536;
			gain_q[0] <= '0;
			gain_q[1] <= '0;
			cnt_q     <= '0;
			cov_q[0]  <= cov_t'(31'd65536000);
			cov_q[1]  <= '0;
			cov_q[2]  <= '0;
			cov_q[3]  <= cov_t'(31'd65536000);
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_LAMBDA: lam_q <= wr_data[30:0];
					REG_DELTA:  delta_q <= wr_data[30:0];
					REG_INIT1:  est_q[0] <= wr_data;
					REG_INIT2:  est_q[1] <= wr_data;
					default: ;
				endcase
			end
			if (accept && mode) begin
				cov_q[0]  <= cov_t'(delta_q);
				cov_q[1]  <= '0;
				cov_q[2]  <= '0;
				cov_q[3]  <= cov_t'(delta_q);
				gain_q[0] <= '0;
				gain_q[1] <= '0;
				cnt_q     <= '0;
			end
			if (st_q == ST_RUN && launched_q && (mul_rsp.done || div_rsp.done)) begin
				case (step_q)
					S_K0: gain_q[0] <= sat32(m);
					S_K1: gain_q[1] <= sat32(m);
					S_E0: est_q[0] <= e_new;
					S_E1: est_q[1] <= e_new;
					S_C0: cov_q[0] <= sat_cov(m);
					S_C1: cov_q[1] <= sat_cov(m);
					S_C2: cov_q[2] <= sat_cov(m);
					S_C3: begin
						cov_q[3] <= sat_cov(m);
						cnt_q    <= cnt_q + 32'd1;
					end
					default: ;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			phi0_q <= regressor_a;
			phi1_q <= regressor_b;
			y_q    <= measured_output;
		end
		if (st_q == ST_RUN && is_alu) begin
			if (step_q == S_DEN)
				den_q <= den_c;
			else
				err_q <= sadd(64'(y_q), -acc_q);
		end
		if (st_q == ST_RUN && launched_q && mul_rsp.done) begin
			case (step_q)
				S_PP0A, S_PP1A, S_QA, S_PRA: acc_q <= m;
				S_PP0B: pp0_q <= sadd(acc_q, m);
				S_PP1B: pp1_q <= sadd(acc_q, m);
				S_QB, S_PRB: acc_q <= sadd(acc_q, m);
				S_KP0: kp_q[0] <= m;
				S_KP1: kp_q[1] <= m;
				S_KP2: kp_q[2] <= m;
				S_KP3: kp_q[3] <= m;
				S_T0A: acc_q <= sadd(c0, -m);
				S_T1A: acc_q <= sadd(c1, -m);
				S_T2A: acc_q <= sadd(c2, -m);
				S_T3A: acc_q <= sadd(c3, -m);
				S_T0B: t_q[0] <= sadd(acc_q, -m);
				S_T1B: t_q[1] <= sadd(acc_q, -m);
				S_T2B: t_q[2] <= sadd(acc_q, -m);
				S_T3B: t_q[3] <= sadd(acc_q, -m);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && out_free) begin
			param_one    <= est_q[0];
			param_two    <= est_q[1];
			gain_one     <= gain_q[0];
			gain_two     <= gain_q[1];
			update_count <= cnt_q;
			skipped      <= skip_q;
		end
	end

	assign result_valid = res_valid_q;

`ifndef NO_ASSERTIONS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (step_q <= S_C3))
		else $error("sequencer step out of range");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.done && div_rsp.done))
		else $error("both units finished at once");
	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st_q) == ST_FIN)
		else $error("result loaded outside finish state");
	a_no_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launched_q |-> !(mul_req.start || div_req.start))
		else $error("unit relaunched while busy");
`endif

endmodule

FILE: tb/tb_rls_two_param_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rls_two_param_estimator: self-checking testbench for the RLS estimator
// A queue-fed driver sends update and restart transactions in random bursts.
// A monitor checks every result field against a fixed-point predictor of the
// covariance, estimates, gains and counter. Several register settings are
// swept, including the extreme values.
// ----------------------------------------------------------------------------
module tb_rls_two_param_estimator;
	import rls_pkg::*;

	typedef struct {
		logic               mode;
		logic signed [31:0] ra;
		logic signed [31:0] rb;
		logic signed [31:0] y;
	} sample_t;

	typedef struct {
		logic signed [31:0] p1;
		logic signed [31:0] p2;
		logic signed [31:0] g1;
		logic signed [31:0] g2;
		logic [31:0]        cnt;
		logic               skip;
	} estimate_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = REG_LAMBDA;
	logic [31:0]        wr_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               mode = 1'b0;
	logic signed [31:0] regressor_a = '0;
	logic signed [31:0] regressor_b = '0;
	logic signed [31:0] measured_output = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [31:0] param_one, param_two, gain_one, gain_two;
	logic [31:0]        update_count;
	logic               skipped;

	rls_two_param_estimator i_dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic signed [63:0] cov_m [4];
	logic signed [63:0] est_m [2];
	logic signed [63:0] gain_m [2];
	logic [31:0]        count_m;
	logic [30:0]        lambda_m, delta_m;

	sample_t   pending_samples [$];
	estimate_t expected_estimates [$];
	int        mismatches = 0;
	bit        hold_request = 1'b0;

	// ---------------- fixed-point helpers ----------------
	function automatic logic [63:0] magn(input logic signed [63:0] a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [63:0] clip_signed(input logic [127:0] m, input bit neg);
		logic signed [63:0] r;
		r = (m > 128'(SMAX)) ? SMAX : $signed(m[63:0]);
		return neg ? -r : r;
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [127:0] p;
		p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> FRAC_BITS;
		return clip_signed(p, (a < 0) != (b < 0));
	endfunction

	function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
		input logic signed [63:0] b, input int s);
		logic [127:0] n, d;
		n = {64'd0, magn(a)} << s;
		d = {64'd0, magn(b)};
		if (d == 0) begin
			if (n == 0)
				return 64'sd0;
			return a < 0 ? -SMAX : SMAX;
		end
		return clip_signed(n / d, (a < 0) != (b < 0));
	endfunction

	function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SMAX))
			return SMAX;
		if (s < -65'(SMAX))
			return -SMAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] clamp_w(input logic signed [63:0] v, input int w);
		logic signed [63:0] mx;
		mx = (64'sd1 <<< (w - 1)) - 64'sd1;
		return v > mx ? mx : (v < -mx - 64'sd1 ? -mx - 64'sd1 : v);
	endfunction

	function automatic void restart_covariance();
		cov_m[0] = 64'(delta_m);
		cov_m[1] = 0;
		cov_m[2] = 0;
		cov_m[3] = 64'(delta_m);
		gain_m[0] = 0;
		gain_m[1] = 0;
		count_m = 0;
	endfunction

	// one RLS step; returns the result fields after the transaction
	function automatic estimate_t rls_predict(input sample_t s);
		logic signed [63:0] f0, f1, pp0, pp1, q, den, k0, k1, pred, err, e;
		logic signed [63:0] kp [4];
		logic signed [63:0] t [4];
		estimate_t r;
		r.skip = 1'b0;
		if (s.mode)
			restart_covariance();
		else begin
			f0 = 64'(s.ra);
			f1 = 64'(s.rb);
			pp0 = add_clip(fx_mul(cov_m[0], f0), fx_mul(cov_m[1], f1));
			pp1 = add_clip(fx_mul(cov_m[2], f0), fx_mul(cov_m[3], f1));
			q = add_clip(fx_mul(f0, pp0), fx_mul(f1, pp1));
			den = add_clip(64'(lambda_m >> (LAMBDA_FRAC - FRAC_BITS)), q);
			if (den == 0)
				r.skip = 1'b1;
			else begin
				k0 = clamp_w(fx_div(pp0, den, FRAC_BITS), 32);
				k1 = clamp_w(fx_div(pp1, den, FRAC_BITS), 32);
				gain_m[0] = k0;
				gain_m[1] = k1;
				pred = add_clip(fx_mul(f0, est_m[0]), fx_mul(f1, est_m[1]));
				err = add_clip(64'(s.y), -pred);
				e = clamp_w(add_clip(est_m[0], fx_mul(k0, err)), 32);
				est_m[0] = e < 1 ? 64'sd1 : e;
				e = clamp_w(add_clip(est_m[1], fx_mul(k1, err)), 32);
				est_m[1] = e < 1 ? 64'sd1 : e;
				kp[0] = fx_mul(k0, f0);
				kp[1] = fx_mul(k0, f1);
				kp[2] = fx_mul(k1, f0);
				kp[3] = fx_mul(k1, f1);
				t[0] = add_clip(add_clip(cov_m[0], -fx_mul(kp[0], cov_m[0])),
					-fx_mul(kp[1], cov_m[2]));
				t[1] = add_clip(add_clip(cov_m[1], -fx_mul(kp[0], cov_m[1])),
					-fx_mul(kp[1], cov_m[3]));
				t[2] = add_clip(add_clip(cov_m[2], -fx_mul(kp[2], cov_m[0])),
					-fx_mul(kp[3], cov_m[2]));
				t[3] = add_clip(add_clip(cov_m[3], -fx_mul(kp[2], cov_m[1])),
					-fx_mul(kp[3], cov_m[3]));
				for (int i = 0; i < 4; i++)
					cov_m[i] = clamp_w(fx_div(t[i], 64'(lambda_m), LAMBDA_FRAC), COV_WIDTH);
				count_m++;
			end
		end
		r.p1 = est_m[0][31:0];
		r.p2 = est_m[1][31:0];
		r.g1 = gain_m[0][31:0];
		r.g2 = gain_m[1][31:0];
		r.cnt = count_m;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// ---------------- driver ----------------
	int  burst_left = 0, gap_left = 0;
	wire item_taken = item_valid && !item_stall;

	always @(posedge clk) begin
		if (item_taken) begin
			expected_estimates.push_back(rls_predict(pending_samples[0]));
			void'(pending_samples.pop_front());
		end
		if (!item_valid || !item_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				item_valid <= 1'b1;
				mode <= pending_samples[0].mode;
				regressor_a <= pending_samples[0].ra;
				regressor_b <= pending_samples[0].rb;
				measured_output <= pending_samples[0].y;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else
				item_valid <= 1'b0;
		end
	end

	// ---------------- receiver and monitor ----------------
	int  hold_count = 0, pattern_left = 0, stall_pct = 0, idle_cycles = 0;
	wire result_taken = result_valid && !result_stall;

	always @(posedge clk) begin
		estimate_t w;
		if (result_taken) begin
			if (expected_estimates.size() == 0)
				report("unexpected result, param_one", param_one, 0);
			else begin
				w = expected_estimates.pop_front();
				if (param_one !== w.p1) report("param_one", param_one, w.p1);
				if (param_two !== w.p2) report("param_two", param_two, w.p2);
				if (gain_one !== w.g1) report("gain_one", gain_one, w.g1);
				if (gain_two !== w.g2) report("gain_two", gain_two, w.g2);
				if (update_count !== w.cnt) report("update_count", update_count, w.cnt);
				if (skipped !== w.skip) report("skipped", 32'(skipped), 32'(w.skip));
			end
		end
		// stall pattern: long hold on request, else phases of varying density
		if (hold_request && hold_count == 0) begin
			hold_count = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_count > 0) begin
			hold_count--;
			result_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(20, 300);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
			end
			pattern_left--;
			result_stall <= ($urandom_range(1, 100) <= stall_pct);
		end
		// watchdog on cycles without any transaction
		idle_cycles = (item_taken || result_taken) ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic logic signed [31:0] rand_field();
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			3: return 0;
			default: return $signed($urandom_range(0, 524288)) - 32'sd262144;
		endcase
	endfunction

	task automatic queue_sample(input logic m, input logic signed [31:0] a,
		input logic signed [31:0] b, input logic signed [31:0] y);
		sample_t s;
		s.mode = m;
		s.ra = a;
		s.rb = b;
		s.y = y;
		pending_samples.push_back(s);
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || expected_estimates.size() > 0 || item_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// block is idle here, so the predictor follows the write at once
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_LAMBDA: lambda_m = val[30:0];
			REG_DELTA:  delta_m = val[30:0];
			REG_INIT1:  est_m[0] = 64'($signed(val));
			default:    est_m[1] = 64'($signed(val));
		endcase
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				queue_sample(1'b1, $urandom, $urandom, $urandom);
			else
				queue_sample(1'b0, rand_field(), rand_field(), rand_field());
		end
	endtask

	initial begin
		lambda_m = 31'd1063004406;
		delta_m = 31'd65536000;
		est_m[0] = 65536;
		est_m[1] = 65536;
		restart_covariance();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: field extremes, restart, then zero lambda cases
		queue_sample(1'b0, 32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000);
		queue_sample(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		queue_sample(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		queue_sample(1'b0, 0, 0, 32'shFFFF_0000);
		queue_sample(1'b0, 32'shFFFF_0000, 32'sh0001_0000, 32'sh8000_0000);
		queue_sample(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF);
		queue_sample(1'b0, 32'sh0000_0001, 32'shFFFF_FFFF, 0);
		wait_drained();
		write_reg(REG_LAMBDA, 32'd0);
		queue_sample(1'b1, 0, 0, 0);
		queue_sample(1'b0, 0, 0, 32'sh0001_0000);
		queue_sample(1'b0, 32'sh0001_0000, 32'shFFFF_0000, 32'sh0003_0000);
		queue_sample(1'b0, 0, 0, 0);
		random_phase(30);
		wait_drained();

		// lambda at 1.0, extreme deltas and initial estimates
		write_reg(REG_LAMBDA, 32'h4000_0000);
		write_reg(REG_DELTA, 32'h7FFF_FFFF);
		write_reg(REG_INIT1, 32'h8000_0000);
		write_reg(REG_INIT2, 32'h7FFF_FFFF);
		queue_sample(1'b1, 0, 0, 0);
		random_phase(120);
		wait_drained();

		// long receiver hold while the sender keeps offering
		hold_request = 1'b1;
		write_reg(REG_DELTA, 32'd0);
		write_reg(REG_INIT1, 32'd0);
		write_reg(REG_INIT2, 32'h0001_0000);
		queue_sample(1'b1, 0, 0, 0);
		random_phase(120);
		wait_drained();

		write_reg(REG_LAMBDA, 32'h7FFF_FFFF);
		write_reg(REG_DELTA, 32'd65536);
		queue_sample(1'b1, 0, 0, 0);
		random_phase(120);
		wait_drained();

		write_reg(REG_LAMBDA, 32'd1);
		write_reg(REG_DELTA, 32'h0010_0000);
		queue_sample(1'b1, 0, 0, 0);
		random_phase(100);
		wait_drained();

		write_reg(REG_LAMBDA, 32'd1063004406);
		write_reg(REG_DELTA, 32'd65536000);
		write_reg(REG_INIT1, 32'h7FFF_FFFF);
		write_reg(REG_INIT2, 32'h8000_0000);
		queue_sample(1'b1, 0, 0, 0);
		random_phase(200);
		wait_drained();

		write_reg(REG_LAMBDA, 32'($urandom_range(0, 32'h4000_0000)));
		write_reg(REG_DELTA, $urandom & 32'h7FFF_FFFF);
		write_reg(REG_INIT1, $urandom);
		write_reg(REG_INIT2, $urandom);
		queue_sample(1'b1, 0, 0, 0);
		random_phase(200);
		wait_drained();
		repeat (50) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: rls_two_param_estimator.f
hw/rtl/rls_pkg.sv
hw/rtl/rls_mul.sv
hw/rtl/rls_div.sv
hw/rtl/rls_two_param_estimator.sv
tb/tb_rls_two_param_estimator.sv
